/* rtl/core/stpq_pkg.sv */
`default_nettype none

package stpq_pkg;

   // Command codes carried in the cmd field.
   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   // Status codes returned with every result.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_DEL_MISS  = 2'd2;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd3;

   // One input beat.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  priority_req;
      logic [15:0] submit_time;
      logic [7:0]  department;
      logic [15:0] target_time;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic        emitted;
      logic [15:0] task_id;
      logic [1:0]  status;
   } rsp_type;

   // One queue entry, sorted by (prio, stime, dept).
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] stime;
      logic [7:0]  dept;
      logic [15:0] id;
   } entry_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_POP
   } op_type;

   // Control bundle shared by all cells.
   typedef struct packed {
      op_type      op;
      logic        disp;
      entry_type   new_entry;
      logic [7:0]  del_dept;
      logic [15:0] del_time;
   } ctl_type;

endpackage

`default_nettype wire

/* rtl/core/stpq_cell.sv */
`default_nettype none

module stpq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  wire                 clock,
   input  wire                 load,
   input  stpq_pkg::ctl_type   ctl,
   input  wire [CNT_W-1:0]     count,
   input  stpq_pkg::entry_type left_entry,
   input  wire                 left_ge,
   input  wire                 left_seen,
   input  stpq_pkg::entry_type right_entry,
   input  wire                 right_ge,
   output stpq_pkg::entry_type entry,
   output logic                ge,
   output logic                seen
);

   stpq_pkg::entry_type entry_ff;
   stpq_pkg::entry_type entry_in;
   logic                occupied;
   logic                new_first;
   logic                match;

   assign entry = entry_ff;

   // This cell holds a live entry when its position is below the fill count.
   assign occupied = CNT_W'(IDX) < count;

   // The new task sorts strictly ahead of the entry held here.
   always_comb begin
      if (ctl.new_entry.prio != entry_ff.prio) begin
         new_first = ctl.new_entry.prio < entry_ff.prio;
      end else if (ctl.new_entry.stime != entry_ff.stime) begin
         new_first = ctl.new_entry.stime < entry_ff.stime;
      end else begin
         new_first = ctl.new_entry.dept < entry_ff.dept;
      end
   end

   // Insert position is at or before this cell; the sorted order makes this monotonic.
   assign ge = !occupied || new_first;

   // Delete match, and the running flag of a match at or before this cell.
   assign match = occupied && (entry_ff.dept == ctl.del_dept) &&
                  (entry_ff.stime == ctl.del_time);
   assign seen  = left_seen || match;

   // Next entry: keep, shift from a neighbor, or take the new task.
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         stpq_pkg::OP_INSERT: begin
            if (ctl.disp) begin
               // Insert and drop the head in one step: the chain moves toward the head.
               if (!right_ge) begin
                  entry_in = right_entry;
               end else if (!ge) begin
                  entry_in = ctl.new_entry;
               end
            end else begin
               if (left_ge) begin
                  entry_in = left_entry;
               end else if (ge) begin
                  entry_in = ctl.new_entry;
               end
            end
         end
         stpq_pkg::OP_DELETE: begin
            if (seen) begin
               entry_in = right_entry;
            end
         end
         stpq_pkg::OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sorted_task_priority_queue_top.sv */
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle unless the consumer stalls; every command resolves
// in a single pass through the chain of compare-and-shift cells, one cell per queue slot.
// Input is held off only while a result waits for the consumer.
// Reset empties the queue, sets the task number to one and clears the
// result valid flag; entry contents and the result payload are not cleared.
`default_nettype none

module sorted_task_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  stpq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output stpq_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [15:0]         task_num_ff;
   logic                rsp_valid_ff;
   stpq_pkg::rsp_type   rsp_ff;
   stpq_pkg::rsp_type   rsp_in;
   stpq_pkg::ctl_type   ctl;
   logic                load;
   logic                full;
   logic                empty;

   stpq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic                cell_ge    [QUEUE_DEPTH];
   logic                cell_seen  [QUEUE_DEPTH];

   // The result register parts the two sides; a new beat enters when it drains.
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign load        = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

   // Decode the command into the broadcast control for the cells.
   always_comb begin
      ctl.new_entry.prio  = req_payload.priority_req;
      ctl.new_entry.stime = req_payload.submit_time;
      ctl.new_entry.dept  = req_payload.department;
      ctl.new_entry.id    = task_num_ff;
      ctl.del_dept        = req_payload.department;
      ctl.del_time        = req_payload.target_time;
      ctl.op              = stpq_pkg::OP_NONE;
      case (req_payload.cmd)
         stpq_pkg::CMD_CREATE: begin
            if (!full) begin
               ctl.op = stpq_pkg::OP_INSERT;
            end
         end
         stpq_pkg::CMD_DELETE: begin
            ctl.op = stpq_pkg::OP_DELETE;
         end
         stpq_pkg::CMD_POP: begin
            if (!empty) begin
               ctl.op = stpq_pkg::OP_POP;
            end
         end
         default: begin
            ctl.op = stpq_pkg::OP_NONE;
         end
      endcase
      // Head goes out when the new task lands behind it and was submitted later.
      ctl.disp = (ctl.op == stpq_pkg::OP_INSERT) && !cell_ge[0] &&
                 (req_payload.submit_time > cell_entry[0].stime);
   end

   // The chain of cells, one per queue slot.
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      stpq_pkg::entry_type left_entry;
      stpq_pkg::entry_type right_entry;
      logic                left_ge;
      logic                left_seen;
      logic                right_ge;

      if (k == 0) begin : g_head
         assign left_entry = ctl.new_entry;
         assign left_ge    = 1'b0;
         assign left_seen  = 1'b0;
      end else begin : g_mid_left
         assign left_entry = cell_entry[k-1];
         assign left_ge    = cell_ge[k-1];
         assign left_seen  = cell_seen[k-1];
      end

      if (k == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = ctl.new_entry;
         assign right_ge    = 1'b1;
      end else begin : g_mid_right
         assign right_entry = cell_entry[k+1];
         assign right_ge    = cell_ge[k+1];
      end

      stpq_cell #(
         .IDX   (k),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .load        (load),
         .ctl         (ctl),
         .count       (count_ff),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .left_seen   (left_seen),
         .right_entry (right_entry),
         .right_ge    (right_ge),
         .entry       (cell_entry[k]),
         .ge          (cell_ge[k]),
         .seen        (cell_seen[k])
      );
   end

   // Result and fill count for the current command.
   always_comb begin
      rsp_in.emitted = 1'b0;
      rsp_in.task_id = '0;
      rsp_in.status  = stpq_pkg::STATUS_OK;
      count_in       = count_ff;
      case (req_payload.cmd)
         stpq_pkg::CMD_CREATE: begin
            if (full) begin
               rsp_in.status = stpq_pkg::STATUS_FULL;
            end else if (ctl.disp) begin
               rsp_in.emitted = 1'b1;
               rsp_in.task_id = cell_entry[0].id;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         stpq_pkg::CMD_DELETE: begin
            if (cell_seen[QUEUE_DEPTH-1]) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status = stpq_pkg::STATUS_DEL_MISS;
            end
         end
         stpq_pkg::CMD_POP: begin
            if (empty) begin
               rsp_in.status = stpq_pkg::STATUS_POP_EMPTY;
            end else begin
               rsp_in.emitted = 1'b1;
               rsp_in.task_id = cell_entry[0].id;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_in.status = stpq_pkg::STATUS_OK;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         task_num_ff  <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            count_ff     <= count_in;
            task_num_ff  <= task_num_ff + 16'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // The fill count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");

   // A result without a dispatched task carries task number zero.
   a_idle_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.emitted |-> rsp_ff.task_id == '0)
      else $error("task number set without dispatch");

   // A dropped create leaves the fill count unchanged.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      load && full && (req_payload.cmd == stpq_pkg::CMD_CREATE) |=>
      (count_ff == $past(count_ff)) && (rsp_ff.status == stpq_pkg::STATUS_FULL))
      else $error("full queue changed on create");

   // A pop on an empty queue reports it and dispatches nothing.
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      load && empty && (req_payload.cmd == stpq_pkg::CMD_POP) |=>
      !rsp_ff.emitted && (rsp_ff.status == stpq_pkg::STATUS_POP_EMPTY))
      else $error("pop on empty queue misreported");

endmodule

`default_nettype wire

/* tb/sv/stpq_checker.sv */
`default_nettype none

// Watches both channels of the sorted task queue, keeps its own sorted copy of
// the queued tasks and compares every result beat with the predicted one.
module stpq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  stpq_pkg::req_type req_payload,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  stpq_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count
);

   // Queued tasks, head first, in ascending (priority, submit time, department).
   stpq_pkg::entry_type sorted_tasks[$];
   logic [15:0]         task_number = 16'd1;
   // Predicted result beats, oldest first.
   stpq_pkg::rsp_type   outcome_queue[$];
   int                  fail_tally = 0;

   // True when task a is served strictly before task b.
   function automatic bit sorts_ahead(stpq_pkg::entry_type a, stpq_pkg::entry_type b);
      if (a.prio != b.prio) return a.prio < b.prio;
      if (a.stime != b.stime) return a.stime < b.stime;
      return a.dept < b.dept;
   endfunction

   // Applies one command to the task list and returns the result it causes.
   function automatic stpq_pkg::rsp_type apply_command(stpq_pkg::req_type cmd_beat);
      stpq_pkg::rsp_type   outcome;
      stpq_pkg::entry_type fresh;
      int                  slot;
      bit                  hit;
      outcome        = '0;
      outcome.status = stpq_pkg::STATUS_OK;
      fresh.prio     = cmd_beat.priority_req;
      fresh.stime    = cmd_beat.submit_time;
      fresh.dept     = cmd_beat.department;
      fresh.id       = task_number;
      // Every command consumes a task number, whatever it does.
      task_number    = task_number + 16'd1;
      case (cmd_beat.cmd)
         stpq_pkg::CMD_CREATE: begin
            if (sorted_tasks.size() >= QUEUE_DEPTH) begin
               outcome.status = stpq_pkg::STATUS_FULL;
            end else begin
               // A new task goes behind every task with an equal key.
               slot = sorted_tasks.size();
               hit  = 1'b0;
               for (int k = 0; k < sorted_tasks.size(); k++) begin
                  if (!hit && sorts_ahead(fresh, sorted_tasks[k])) begin
                     slot = k;
                     hit  = 1'b1;
                  end
               end
               sorted_tasks.insert(slot, fresh);
               // A later submit time than the head's dispatches the head.
               if (fresh.stime > sorted_tasks[0].stime) begin
                  outcome.emitted = 1'b1;
                  outcome.task_id = sorted_tasks[0].id;
                  sorted_tasks.delete(0);
               end
            end
         end
         stpq_pkg::CMD_DELETE: begin
            outcome.status = stpq_pkg::STATUS_DEL_MISS;
            hit            = 1'b0;
            for (int k = 0; k < sorted_tasks.size(); k++) begin
               if (!hit && sorted_tasks[k].dept == cmd_beat.department &&
                   sorted_tasks[k].stime == cmd_beat.target_time) begin
                  slot = k;
                  hit  = 1'b1;
               end
            end
            if (hit) begin
               sorted_tasks.delete(slot);
               outcome.status = stpq_pkg::STATUS_OK;
            end
         end
         stpq_pkg::CMD_POP: begin
            if (sorted_tasks.size() == 0) begin
               outcome.status = stpq_pkg::STATUS_POP_EMPTY;
            end else begin
               outcome.emitted = 1'b1;
               outcome.task_id = sorted_tasks[0].id;
               sorted_tasks.delete(0);
            end
         end
         default: begin
            // The unused command code only advances the task number.
         end
      endcase
      return outcome;
   endfunction

   // Result beats are checked before the input beat of the same edge is
   // predicted, since a result always belongs to an earlier input beat.
   always @(posedge clock) begin
      stpq_pkg::rsp_type wanted;
      if (reset) begin
         sorted_tasks.delete();
         outcome_queue.delete();
         task_number = 16'd1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               if (fail_tally < 10) begin
                  $display("unexpected result beat: emitted %0d task_id %0d status %0d",
                           rsp_payload.emitted, rsp_payload.task_id, rsp_payload.status);
               end
               fail_tally++;
            end else begin
               wanted = outcome_queue[0];
               outcome_queue.delete(0);
               if (rsp_payload.emitted !== wanted.emitted ||
                   rsp_payload.task_id !== wanted.task_id ||
                   rsp_payload.status !== wanted.status) begin
                  if (fail_tally < 10) begin
                     $display("result mismatch: expected emitted %0d task_id %0d status %0d, %s",
                              wanted.emitted, wanted.task_id, wanted.status, "got");
                     $display("   emitted %0d task_id %0d status %0d",
                              rsp_payload.emitted, rsp_payload.task_id, rsp_payload.status);
                  end
                  fail_tally++;
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome_queue.insert(outcome_queue.size(), apply_command(req_payload));
         end
      end
      fail_count    <= fail_tally;
      pending_count <= outcome_queue.size();
   end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

// Drives the sorted task queue with directed and random command beats under
// changing back-pressure and reports the verdict from the checker.
module testbench;

   localparam int         QUEUE_DEPTH  = 16;
   // Command code that the block ignores apart from taking a task number.
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         DIRECTED_LEN = 25;
   localparam int         PHASE_LEN    = 400;
   // Input beat count after which the random part starts no new command burst.
   localparam int         TOTAL_ITEMS  = 1200;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   stpq_pkg::req_type req_payload = '0;
   logic              rsp_ready   = 1'b0;
   wire               req_ready;
   wire               rsp_valid;
   stpq_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                pending_count;

   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          beats_sent    = 0;
   // Recently created {department, submit time} pairs, used to aim deletes.
   logic [23:0] recent_keys[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_task_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   stpq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // The consumer stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic stpq_pkg::req_type make_req(logic [1:0] cmd, logic [7:0] prio,
                                                  logic [15:0] stime, logic [7:0] dept,
                                                  logic [15:0] ttime);
      stpq_pkg::req_type beat;
      beat.cmd          = cmd;
      beat.priority_req = prio;
      beat.submit_time  = stime;
      beat.department   = dept;
      beat.target_time  = ttime;
      return beat;
   endfunction

   // Offers one beat after a random idle gap and holds it until accepted.
   task automatic push_req(input stpq_pkg::req_type beat);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (beat.cmd == stpq_pkg::CMD_CREATE) begin
         recent_keys.insert(recent_keys.size(), {beat.department, beat.submit_time});
         if (recent_keys.size() > 32) recent_keys.delete(0);
      end
   endtask

   // Random command sequences until at least the given number of beats has gone in.
   task automatic run_random(input int stop_at);
      int          pick;
      int          count;
      int          prio_top;
      int          dept_top;
      logic [15:0] stime;
      logic [23:0] key;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // Burst of creates with falling submit times fills the queue;
            // narrow key ranges give plenty of equal keys.
            count    = $urandom_range(20, 4);
            prio_top = ($urandom_range(1) != 0) ? 3 : 255;
            dept_top = ($urandom_range(1) != 0) ? 3 : 255;
            stime    = 16'($urandom);
            for (int i = 0; i < count; i++) begin
               if ($urandom_range(3) == 0) stime = 16'($urandom);
               push_req(make_req(stpq_pkg::CMD_CREATE, 8'($urandom_range(prio_top)), stime,
                                 8'($urandom_range(dept_top)), 16'($urandom)));
               stime = stime - 16'($urandom_range(2));
            end
         end else if (pick < 65) begin
            // Deletes, mostly aimed at tasks created a little earlier.
            count = $urandom_range(4, 1);
            for (int i = 0; i < count; i++) begin
               if (recent_keys.size() != 0 && $urandom_range(9) < 8) begin
                  key = recent_keys[$urandom_range(recent_keys.size() - 1)];
               end else begin
                  key = 24'($urandom);
               end
               push_req(make_req(stpq_pkg::CMD_DELETE, 8'($urandom), 16'($urandom),
                                 key[23:16], key[15:0]));
            end
         end else if (pick < 85) begin
            count = $urandom_range(6, 1);
            for (int i = 0; i < count; i++) begin
               push_req(make_req(stpq_pkg::CMD_POP, 8'($urandom), 16'($urandom),
                                 8'($urandom), 16'($urandom)));
            end
         end else begin
            // Noise: any command code with fully random fields.
            count = $urandom_range(4, 1);
            for (int i = 0; i < count; i++) begin
               push_req(make_req(2'($urandom), 8'($urandom), 16'($urandom),
                                 8'($urandom), 16'($urandom)));
            end
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue cases, the unused code, extreme keys, a dispatch
      // on create, a delete hit, then a fill up to the full-queue drop.
      push_req(make_req(stpq_pkg::CMD_POP, 8'd0, 16'd0, 8'd0, 16'd0));
      push_req(make_req(stpq_pkg::CMD_DELETE, 8'd0, 16'd0, 8'd0, 16'd0));
      push_req(make_req(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
      push_req(make_req(stpq_pkg::CMD_CREATE, 8'hFF, 16'hFFFF, 8'hFF, 16'h0000));
      push_req(make_req(stpq_pkg::CMD_CREATE, 8'h00, 16'h0000, 8'h00, 16'hFFFF));
      push_req(make_req(stpq_pkg::CMD_CREATE, 8'h80, 16'd100, 8'h01, 16'd0));
      push_req(make_req(stpq_pkg::CMD_DELETE, 8'h00, 16'h0000, 8'hFF, 16'hFFFF));
      push_req(make_req(stpq_pkg::CMD_POP, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF));
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         push_req(make_req(stpq_pkg::CMD_CREATE, (i % 3 == 0) ? 8'hFF : 8'h07, 16'h0000,
                           8'(i % 4), 16'($urandom)));
      end

      // Random part in three back-pressure phases; the last runs on up to
      // the total item count.
      req_idle_pct  = 24;
      rsp_stall_pct = 68;
      run_random(DIRECTED_LEN + PHASE_LEN);
      req_idle_pct  = 68;
      rsp_stall_pct = 24;
      run_random(DIRECTED_LEN + 2 * PHASE_LEN);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random(TOTAL_ITEMS);
      req_valid <= 1'b0;

      // Drain outstanding results, then allow for a stray late beat.
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #4000000;
      $display("testbench failed");
      $finish;
   end

endmodule

`default_nettype wire
